FILE: rtl/b64d_pkg.sv
// Shared types, character codes and decode helpers for the base64 stream decoder.
package b64d_pkg;

  typedef struct packed {
    logic [7:0] text_char;
    logic       end_of_text;
  } b64d_in_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last_of_text;
  } b64d_out_t;

  // One queue entry: up to three bytes decoded from one group, plus the end marker.
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      cnt;
    logic            last;
  } b64d_entry_t;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
  localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
  localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
  localparam logic [7:0] CHAR_PLUS    = 8'h2b;
  localparam logic [7:0] CHAR_SLASH   = 8'h2f;
  localparam logic [7:0] CHAR_PAD     = 8'h3d;

  localparam logic [6:0] SEXTET_NONE  = 7'd64;
  localparam logic [6:0] OFS_LOWER    = 7'd26;
  localparam logic [6:0] OFS_DIGIT    = 7'd52;
  localparam logic [6:0] SEXTET_PLUS  = 7'd62;
  localparam logic [6:0] SEXTET_SLASH = 7'd63;

  // Map a character to 0..63, or SEXTET_NONE outside the alphabet.
  function automatic logic [6:0] sextet_of(logic [7:0] c);
    logic [6:0] v;
    v = SEXTET_NONE;
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      v = 7'(c - CHAR_UPPER_A);
    end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
      v = 7'(c - CHAR_LOWER_A) + OFS_LOWER;
    end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
      v = 7'(c - CHAR_DIGIT_0) + OFS_DIGIT;
    end else if (c == CHAR_PLUS) begin
      v = SEXTET_PLUS;
    end else if (c == CHAR_SLASH) begin
      v = SEXTET_SLASH;
    end
    return v;
  endfunction

  // Pack four sextets into three bytes, most significant bits first.
  function automatic logic [2:0][7:0] pack_group(logic [5:0] s0, logic [5:0] s1,
                                                 logic [5:0] s2, logic [5:0] s3);
    logic [2:0][7:0] b;
    b[0] = {s0, s1[5:4]};
    b[1] = {s1[3:0], s2[5:2]};
    b[2] = {s2[1:0], s3};
    return b;
  endfunction

endpackage

FILE: rtl/base64_stream_decoder_core.sv
// Base64 stream decoder: one character in per cycle unless in_stall, decoded bytes out one per cycle unless out_stall.
// Path: an accepted character's entry is written to the queue; from the queue head the bytes
// are loaded into the output register while the output is not stalled.
// Flow: one character per cycle while in_stall is low; a completed group gives three bytes,
// sent one at a time by the single output register; the entry queue absorbs the burst, in_stall while full.
// Reset (rst, synchronous): clears group count, stop flag, queue pointers and output valid.
module base64_stream_decoder_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  b64d_pkg::b64d_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output b64d_pkg::b64d_out_t out_data
);
  import b64d_pkg::*;

  b64d_entry_t wr_ent;
  b64d_entry_t head;
  logic        push;
  logic        pop;
  logic        q_full;
  logic        q_empty;

  assign in_stall = q_full;

  b64d_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (in_valid && !in_stall),
    .in_data (in_data),
    .push    (push),
    .ent     (wr_ent)
  );

  b64d_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_ent (wr_ent),
    .pop    (pop),
    .rd_ent (head),
    .full   (q_full),
    .empty  (q_empty)
  );

  b64d_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (q_empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: rtl/b64d_front.sv
// Front end: takes characters, tracks the group and stop state, and builds queue entries.
module b64d_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  b64d_pkg::b64d_in_t   in_data,
  output logic                 push,
  output b64d_pkg::b64d_entry_t ent
);
  import b64d_pkg::*;

  logic [2:0][5:0] sextets, sextets_next;
  logic [1:0]      gcnt, gcnt_next;
  logic            stopped, stopped_next;
  logic [6:0]      v;
  logic            bad;

  always_comb begin
    sextets_next = sextets;
    gcnt_next    = gcnt;
    stopped_next = stopped;
    ent          = '0;
    v            = sextet_of(in_data.text_char);
    bad          = (in_data.text_char == CHAR_PAD) || v[6];
    if (!stopped) begin
      if (bad) begin
        stopped_next = 1'b1;
      end else if (gcnt == 2'd3) begin
        ent.bytes = pack_group(sextets[0], sextets[1], sextets[2], v[5:0]);
        ent.cnt   = 2'd3;
        gcnt_next = 2'd0;
      end else begin
        sextets_next[gcnt] = v[5:0];
        gcnt_next          = gcnt + 2'd1;
      end
    end
    if (in_data.end_of_text) begin
      // Flush a partial group of two or three sextets.
      if (gcnt_next >= 2'd2) begin
        ent.bytes = pack_group(sextets_next[0], sextets_next[1],
                               (gcnt_next == 2'd3) ? sextets_next[2] : 6'd0, 6'd0);
        ent.cnt   = gcnt_next - 2'd1;
      end
      ent.last     = 1'b1;
      gcnt_next    = 2'd0;
      stopped_next = 1'b0;
    end
  end

  assign push = accept && ((ent.cnt != 2'd0) || in_data.end_of_text);

  always_ff @(posedge clk) begin
    if (rst) begin
      gcnt    <= 2'd0;
      stopped <= 1'b0;
      sextets <= '0;
    end else if (accept) begin
      gcnt    <= gcnt_next;
      stopped <= stopped_next;
      sextets <= sextets_next;
    end
  end

endmodule

FILE: rtl/b64d_queue.sv
// Short entry queue between the front end and the byte sequencer.
module b64d_queue #(
  parameter int DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  b64d_pkg::b64d_entry_t wr_ent,
  input  logic                  pop,
  output b64d_pkg::b64d_entry_t rd_ent,
  output logic                  full,
  output logic                  empty
);
  import b64d_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  b64d_entry_t     slots [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign full   = (count == CW'(DEPTH));
  assign empty  = (count == '0);
  assign rd_ent = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: rtl/b64d_back.sv
// Back end: walks each queue entry byte by byte into the output register.
module b64d_back (
  input  logic                  clk,
  input  logic                  rst,
  input  b64d_pkg::b64d_entry_t head,
  input  logic                  empty,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output b64d_pkg::b64d_out_t   out_data
);
  import b64d_pkg::*;

  logic [1:0] idx;
  logic [1:0] last_idx;
  logic       at_end;
  logic       load;
  logic       take;

  assign last_idx = (head.cnt == 2'd0) ? 2'd0 : head.cnt - 2'd1;
  assign at_end   = (idx == last_idx);
  assign load     = !out_valid || !out_stall;
  assign take     = load && !empty;
  assign pop      = take && at_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else begin
      if (load) begin
        out_valid <= !empty;
      end
      if (take) begin
        idx <= at_end ? 2'd0 : idx + 2'd1;
      end
    end
  end

  // Empty-end entries carry no byte and emit a single marker transaction.
  always_ff @(posedge clk) begin
    if (take) begin
      out_data.data_byte    <= head.bytes[idx];
      out_data.byte_valid   <= (head.cnt != 2'd0);
      out_data.last_of_text <= head.last && at_end;
    end
  end

endmodule

FILE: rtl/b64d_checker.sv
// Port-level checks for the base64 stream decoder, bound to the top level.
module b64d_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input b64d_pkg::b64d_in_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input b64d_pkg::b64d_out_t out_data
);
  import b64d_pkg::*;

  // Hold a stalled output transaction.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output transaction changed");

  // A transaction without a byte is only the end marker.
  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.byte_valid |-> out_data.last_of_text)
    else $error("byte-less transaction not marked last");

  // Drop output valid after reset.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // The entry of an accepted end of text passes through the queue into the output
  // register, so output valid comes up.
  a_eot_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_data.end_of_text && !out_valid |-> ##2 out_valid)
    else $error("end of text produced no transaction");

endmodule

bind base64_stream_decoder_core b64d_checker u_b64d_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
